@@ hdl/mrs_pkg.sv @@
// types and codes shared by the ring sorter
package mrs_pkg;

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_SORT  = 2'd1,
        REQ_READ  = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_G_RD,
        ST_G_WR,
        ST_S_RDI,
        ST_S_HAVEI,
        ST_S_CMP,
        ST_S_PUT,
        ST_P_RD,
        ST_P_WR,
        ST_DONE
    } state_t;

    localparam logic CFG_NUM_ROWS = 1'b0;
    localparam logic CFG_NUM_COLS = 1'b1;

    localparam int SIZE_W = 5;

endpackage

@@ hdl/mrs_ram.sv @@
// generic single write port, single read port ram with registered read
module mrs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hdl/matrix_ring_sort_top.sv @@
// Matrix ring sorter top level. The matrix lives in one RAM and the ring being sorted in a
// second one. A write transaction gives no result; a read transaction gives one. A sort
// transaction walks each ring: it gathers the ring's elements into the ring RAM, sorts
// them with insertion steps that move one element at a time, writes them back to the
// matrix, and gives a final result; every step waits on the registered read of the RAMs.
// No new transaction is taken while a sort runs.
module matrix_ring_sort_top
    import mrs_pkg::*;
#(
    parameter int MAX_ROWS   = 16,
    parameter int MAX_COLS   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_addr,
    input  logic [SIZE_W-1:0]    cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_req_type,
    input  logic [3:0]           s_row_index,
    input  logic [3:0]           s_col_index,
    input  logic signed [31:0]   s_elem_value,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [31:0]   m_read_value,
    output logic                 m_sort_done
);

    localparam int DEPTH      = MAX_ROWS * MAX_COLS;
    localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RING_DEPTH = 2 * (MAX_ROWS + MAX_COLS);
    localparam int RAW        = $clog2(RING_DEPTH);
    localparam int RDW        = $clog2(RING_DEPTH + 1);
    localparam int RW         = $clog2(MAX_ROWS) + 1;
    localparam int CW         = $clog2(MAX_COLS) + 1;

    state_t state_reg, state_next;

    logic [SIZE_W-1:0] num_rows_reg, num_cols_reg;
    logic [RW-1:0] rs_reg, rs_next, re_reg, re_next, r_reg, r_next;
    logic [CW-1:0] cs_reg, cs_next, ce_reg, ce_next, c_reg, c_next;
    logic [RAW-1:0] n_reg, n_next, i_reg, i_next, pos_reg, pos_next;
    logic [DATA_WIDTH-1:0] v_reg, v_next;
    logic read_zero_reg, read_zero_next;
    logic out_valid_reg, out_valid_next;
    logic signed [31:0] out_value_reg, out_value_next;
    logic out_done_reg, out_done_next;

    logic [RW-1:0] rows_m1;
    logic [CW-1:0] cols_m1;
    logic [RDW-1:0] h, w, ring_len;
    logic [RW-1:0] adv_r;
    logic [CW-1:0] adv_c;
    logic last_elem, more_rings, in_inside, out_free;

    logic mat_we;
    logic [AW-1:0] mat_waddr, mat_raddr;
    logic [DATA_WIDTH-1:0] mat_wdata, mat_rdata;
    logic ring_we;
    logic [RAW-1:0] ring_waddr, ring_raddr;
    logic [DATA_WIDTH-1:0] ring_wdata, ring_rdata;

    function automatic logic [AW-1:0] mat_addr(input int r, input int c);
        mat_addr = AW'(r * MAX_COLS + c);
    endfunction

    mrs_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH), .AW(AW)) u_mat_ram (
        .aclk  (aclk),
        .we    (mat_we),
        .waddr (mat_waddr),
        .wdata (mat_wdata),
        .raddr (mat_raddr),
        .rdata (mat_rdata)
    );

    mrs_ram #(.WIDTH(DATA_WIDTH), .DEPTH(RING_DEPTH), .AW(RAW)) u_ring_ram (
        .aclk  (aclk),
        .we    (ring_we),
        .waddr (ring_waddr),
        .wdata (ring_wdata),
        .raddr (ring_raddr),
        .rdata (ring_rdata)
    );

    always_comb begin
        if (num_rows_reg == '0) begin
            rows_m1 = '0;
        end else if (int'(num_rows_reg) > MAX_ROWS) begin
            rows_m1 = RW'(MAX_ROWS - 1);
        end else begin
            rows_m1 = RW'(num_rows_reg - SIZE_W'(1));
        end
        if (num_cols_reg == '0) begin
            cols_m1 = '0;
        end else if (int'(num_cols_reg) > MAX_COLS) begin
            cols_m1 = CW'(MAX_COLS - 1);
        end else begin
            cols_m1 = CW'(num_cols_reg - SIZE_W'(1));
        end
    end

    // ring geometry and clockwise step
    always_comb begin
        h = RDW'(re_reg) - RDW'(rs_reg) + RDW'(1);
        w = RDW'(ce_reg) - RDW'(cs_reg) + RDW'(1);
        if (h == RDW'(1)) begin
            ring_len = w;
        end else if (w == RDW'(1)) begin
            ring_len = h;
        end else begin
            ring_len = RDW'(2) * (h + w) - RDW'(4);
        end
        adv_r = r_reg;
        adv_c = c_reg;
        if (r_reg == rs_reg && c_reg < ce_reg) begin
            adv_c = c_reg + CW'(1);
        end else if (c_reg == ce_reg && r_reg < re_reg) begin
            adv_r = r_reg + RW'(1);
        end else if (r_reg == re_reg && c_reg > cs_reg) begin
            adv_c = c_reg - CW'(1);
        end else begin
            adv_r = r_reg - RW'(1);
        end
        last_elem  = (RDW'(n_reg) + RDW'(1)) == ring_len;
        more_rings = (RW'(rs_reg + RW'(2)) <= re_reg) && (CW'(cs_reg + CW'(2)) <= ce_reg)
                     && (re_reg >= RW'(2)) && (ce_reg >= CW'(2));
        in_inside  = (int'(s_row_index) < MAX_ROWS) && (int'(s_col_index) < MAX_COLS);
        out_free   = !out_valid_reg || m_ready;
    end

    always_comb begin
        s_ready = 1'b0;
        if (state_reg == ST_IDLE) begin
            s_ready = (s_req_type == REQ_WRITE) || (s_req_type == REQ_NONE) || out_free;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    if (s_req_type == REQ_SORT) begin
                        state_next = ST_G_RD;
                    end else if (s_req_type == REQ_READ) begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:  state_next = ST_IDLE;
            ST_G_RD:  state_next = ST_G_WR;
            ST_G_WR: begin
                if (!last_elem) begin
                    state_next = ST_G_RD;
                end else if (ring_len == RDW'(1)) begin
                    state_next = ST_P_RD;
                end else begin
                    state_next = ST_S_RDI;
                end
            end
            ST_S_RDI:   state_next = ST_S_HAVEI;
            ST_S_HAVEI: state_next = ST_S_CMP;
            ST_S_CMP: begin
                if ($signed(ring_rdata) > $signed(v_reg)) begin
                    if (pos_reg == RAW'(1)) begin
                        state_next = ST_S_PUT;
                    end
                end else if ((RDW'(i_reg) + RDW'(1)) == ring_len) begin
                    state_next = ST_P_RD;
                end else begin
                    state_next = ST_S_RDI;
                end
            end
            ST_S_PUT: begin
                if ((RDW'(i_reg) + RDW'(1)) == ring_len) begin
                    state_next = ST_P_RD;
                end else begin
                    state_next = ST_S_RDI;
                end
            end
            ST_P_RD: state_next = ST_P_WR;
            ST_P_WR: begin
                if (!last_elem) begin
                    state_next = ST_P_RD;
                end else if (more_rings) begin
                    state_next = ST_G_RD;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        rs_next = rs_reg;
        re_next = re_reg;
        cs_next = cs_reg;
        ce_next = ce_reg;
        r_next = r_reg;
        c_next = c_reg;
        n_next = n_reg;
        i_next = i_reg;
        pos_next = pos_reg;
        v_next = v_reg;
        read_zero_next = read_zero_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_value_next = out_value_reg;
        out_done_next = out_done_reg;
        mat_we = 1'b0;
        mat_waddr = mat_addr(int'(r_reg), int'(c_reg));
        mat_wdata = ring_rdata;
        mat_raddr = mat_addr(int'(r_reg), int'(c_reg));
        ring_we = 1'b0;
        ring_waddr = n_reg;
        ring_wdata = mat_rdata;
        ring_raddr = n_reg;
        case (state_reg)
            ST_IDLE: begin
                mat_waddr = mat_addr(int'(s_row_index), int'(s_col_index));
                mat_raddr = mat_addr(int'(s_row_index), int'(s_col_index));
                mat_wdata = DATA_WIDTH'(s_elem_value);
                read_zero_next = !in_inside;
                if (s_valid && s_ready) begin
                    if (s_req_type == REQ_WRITE) begin
                        mat_we = in_inside;
                    end else if (s_req_type == REQ_SORT) begin
                        rs_next = '0;
                        cs_next = '0;
                        re_next = rows_m1;
                        ce_next = cols_m1;
                        r_next = '0;
                        c_next = '0;
                        n_next = '0;
                    end
                end
            end
            ST_READ: begin
                out_valid_next = 1'b1;
                out_done_next = 1'b0;
                out_value_next = read_zero_reg ? 32'sd0 : 32'($signed(mat_rdata));
            end
            ST_G_WR: begin
                ring_we = 1'b1;
                r_next = adv_r;
                c_next = adv_c;
                n_next = n_reg + RAW'(1);
                i_next = RAW'(1);
                if (last_elem) begin
                    r_next = rs_reg;
                    c_next = cs_reg;
                    n_next = '0;
                end
            end
            ST_S_RDI: begin
                ring_raddr = i_reg;
            end
            ST_S_HAVEI: begin
                v_next = ring_rdata;
                pos_next = i_reg;
                ring_raddr = i_reg - RAW'(1);
            end
            ST_S_CMP: begin
                ring_we = 1'b1;
                ring_waddr = pos_reg;
                if ($signed(ring_rdata) > $signed(v_reg)) begin
                    ring_wdata = ring_rdata;
                    pos_next = pos_reg - RAW'(1);
                    ring_raddr = pos_reg - RAW'(2);
                end else begin
                    ring_wdata = v_reg;
                    i_next = i_reg + RAW'(1);
                end
            end
            ST_S_PUT: begin
                ring_we = 1'b1;
                ring_waddr = '0;
                ring_wdata = v_reg;
                i_next = i_reg + RAW'(1);
            end
            ST_P_WR: begin
                mat_we = 1'b1;
                r_next = adv_r;
                c_next = adv_c;
                n_next = n_reg + RAW'(1);
                if (last_elem) begin
                    n_next = '0;
                    rs_next = rs_reg + RW'(1);
                    re_next = re_reg - RW'(1);
                    cs_next = cs_reg + CW'(1);
                    ce_next = ce_reg - CW'(1);
                    r_next = rs_reg + RW'(1);
                    c_next = cs_reg + CW'(1);
                end
            end
            ST_DONE: begin
                out_valid_next = 1'b1;
                out_done_next = 1'b1;
                out_value_next = 32'sd0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            num_rows_reg <= SIZE_W'(16);
            num_cols_reg <= SIZE_W'(16);
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) begin
                if (cfg_addr == CFG_NUM_ROWS) begin
                    num_rows_reg <= cfg_wdata;
                end else begin
                    num_cols_reg <= cfg_wdata;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        rs_reg <= rs_next;
        re_reg <= re_next;
        cs_reg <= cs_next;
        ce_reg <= ce_next;
        r_reg <= r_next;
        c_reg <= c_next;
        n_reg <= n_next;
        i_reg <= i_next;
        pos_reg <= pos_next;
        v_reg <= v_next;
        read_zero_reg <= read_zero_next;
        out_value_reg <= out_value_next;
        out_done_reg <= out_done_next;
    end

    assign m_valid = out_valid_reg;
    assign m_read_value = out_value_reg;
    assign m_sort_done = out_done_reg;

endmodule
